>>> sv/bd3_pkg.sv
package bd3_pkg;

    // Configuration register map (index = paddr[2])
    localparam int  PADDR_W          = 3;
    localparam int  PDATA_W          = 32;
    localparam logic REG_LINE_WIDTH   = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // Register field widths and reset values
    localparam int          LW_BITS     = 10;
    localparam int          FH_BITS     = 9;
    localparam logic [9:0]  LW_RESET    = 10'd640;
    localparam logic [8:0]  FH_RESET    = 9'd480;

    // Line store entry: [1] upper line, [0] middle line
    localparam int LINE_BITS = 2;

    // 3x3 window: three columns of three taps, oldest column in the low bits;
    // inside a column bit 0 is the top row, bit 2 the bottom row.
    localparam int         WIN_BITS    = 9;
    localparam logic [8:0] TOP_TAPS    = 9'h049;
    localparam logic [8:0] BOTTOM_TAPS = 9'h124;
    localparam logic [8:0] LEFT_TAPS   = 9'h007;
    localparam logic [8:0] RIGHT_TAPS  = 9'h1C0;

    // Per-item control carried from the address stage to the window stage
    typedef struct packed {
        logic pixel;
        logic clear;      // restart window before shifting
        logic produce;    // item yields a result
        logic clip_top;
        logic clip_bottom;
        logic clip_left;
        logic end_of_line;
        logic end_of_frame;
    } s1_ctrl_t;

endpackage

>>> sv/bd3_if.sv
// Input stream: one pixel or flush tick per transfer
interface bd3_in_if;
    logic valid;
    logic ready;
    logic kind;
    logic pixel;

    modport source (output valid, output kind, output pixel, input ready);
    modport sink (input valid, input kind, input pixel, output ready);
endinterface

// Output stream: one dilated pixel per transfer
interface bd3_out_if;
    logic valid;
    logic ready;
    logic dilated;
    logic end_of_line;
    logic end_of_frame;

    modport source (output valid, output dilated, output end_of_line,
                    output end_of_frame, input ready);
    modport sink (input valid, input dilated, input end_of_line,
                  input end_of_frame, output ready);
endinterface

>>> sv/bd3_line_store.sv
// Two line buffers packed into one synchronous RAM with a registered read port.
// A write in the same cycle as a read of the same entry is forwarded.
module bd3_line_store #(
    parameter int DEPTH = 640
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         rd_en,
    input  logic [$clog2(DEPTH)-1:0]     rd_addr,
    input  logic                         wr_en,
    input  logic [$clog2(DEPTH)-1:0]     wr_addr,
    input  logic [bd3_pkg::LINE_BITS-1:0] wr_data,
    output logic [bd3_pkg::LINE_BITS-1:0] rd_data
);
    import bd3_pkg::*;

    logic [LINE_BITS-1:0] mem [DEPTH];
    logic [LINE_BITS-1:0] q_reg;
    logic [LINE_BITS-1:0] fwd_data_reg;
    logic                 fwd_hit_reg;

    // RAM: write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            q_reg        <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    // Read-during-write bypass flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_hit_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : q_reg;

endmodule

>>> sv/binary_dilation_3x3_core.sv
// Streaming 3x3 binary dilation.
// in_stream carries one item per transfer: kind 0 is a pixel in raster order,
// kind 1 a flush tick. out_stream carries the dilated pixel with end_of_line
// and end_of_frame marks. Each result is the OR of the 3x3 neighborhood,
// clipped at the frame edges.
// Results lag the input by line_width + 1 items; after the last pixel of a
// frame, line_width + 1 flush ticks drain the rest. Flush ticks outside a
// drain are dropped. A pixel during a drain abandons it and starts a frame.
// Throughput is one item per cycle while out_stream does not stall. An
// accepted item reads the line RAM at the address stage, shifts the window
// and writes back at the window stage; its result then sits in the output register.
// The APB port sets line_width (offset 0) and frame_height (offset 4); a
// write restarts the frame. Write only while the stream is idle.
// Reset clears the counters, the window and the pipeline; the line RAM holds
// no defined data until written and needs no clearing.
// When out_stream stalls, the output register holds; if the window stage
// item yields a result, it holds too and in_stream ready drops in the same cycle.
module binary_dilation_3x3_core #(
    parameter int MAX_WIDTH  = 640,
    parameter int MAX_HEIGHT = 480
) (
    input  logic                          clk,
    input  logic                          rst_n,
    bd3_in_if.sink                        in_stream,
    bd3_out_if.source                     out_stream,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bd3_pkg::PADDR_W-1:0]   paddr,
    input  logic [bd3_pkg::PDATA_W-1:0]   pwdata,
    output logic [bd3_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import bd3_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);        // column index
    localparam int RW  = $clog2(MAX_HEIGHT + 2);   // input row, runs past h
    localparam int ORW = $clog2(MAX_HEIGHT);       // output row

    // Configuration registers
    logic [LW_BITS-1:0] line_width_reg;
    logic [FH_BITS-1:0] frame_height_reg;
    logic               cfg_we;

    // Address-stage counters
    logic [CW-1:0]  in_col_reg,  in_col_next;
    logic [RW-1:0]  in_row_reg,  in_row_next;
    logic [CW-1:0]  out_col_reg, out_col_next;
    logic [ORW-1:0] out_row_reg, out_row_next;
    logic           clear_pend_reg, clear_pend_next;

    // Window stage
    logic           s1_valid_reg, s1_valid_next;
    s1_ctrl_t       s1_ctrl_reg, s1_ctrl_next;
    logic [CW-1:0]  s1_col_reg;
    logic [WIN_BITS-1:0] window_reg, window_next, win_base, win_mask;
    logic [LINE_BITS-1:0] line_q;
    logic           s1_adv;
    logic           dil_now;

    // Output register
    logic out_valid_reg, out_valid_next;
    logic dilated_reg, eol_reg, eof_reg;

    // Clamped frame size
    logic [31:0] used_w, used_h;
    logic        accept, ignore_flush, act, restart;
    logic [CW-1:0]  col_eff;
    logic [RW-1:0]  row_eff;
    logic [CW-1:0]  ocol_eff;
    logic [ORW-1:0] orow_eff;
    logic        col_wrap, row_last, col_last;

    // APB port
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[2])
            REG_LINE_WIDTH:   prdata = PDATA_W'(line_width_reg);
            REG_FRAME_HEIGHT: prdata = PDATA_W'(frame_height_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg   <= LW_RESET;
            frame_height_reg <= FH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (paddr[2])
                REG_LINE_WIDTH:   line_width_reg   <= pwdata[LW_BITS-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= pwdata[FH_BITS-1:0];
                default:          line_width_reg   <= line_width_reg;
            endcase
        end
    end

    // Clamp sizes to 1..MAX
    always_comb
    begin
        if (line_width_reg == '0)
            used_w = 32'd1;
        else if (32'(line_width_reg) > 32'(MAX_WIDTH))
            used_w = 32'(MAX_WIDTH);
        else
            used_w = 32'(line_width_reg);

        if (frame_height_reg == '0)
            used_h = 32'd1;
        else if (32'(frame_height_reg) > 32'(MAX_HEIGHT))
            used_h = 32'(MAX_HEIGHT);
        else
            used_h = 32'(frame_height_reg);
    end

    // Input handshake: take an item whenever the window stage can move on
    assign s1_adv          = !s1_ctrl_reg.produce || !out_valid_reg || out_stream.ready;
    assign in_stream.ready = !s1_valid_reg || s1_adv;
    assign accept          = in_stream.valid && in_stream.ready;
    assign ignore_flush    = in_stream.kind && (32'(in_row_reg) < used_h);
    assign act             = accept && !ignore_flush;
    assign restart         = !in_stream.kind && (32'(in_row_reg) >= used_h);

    // Address stage: position counters, border flags, result gating
    always_comb
    begin
        col_eff  = restart ? '0 : in_col_reg;
        row_eff  = restart ? '0 : in_row_reg;
        ocol_eff = restart ? '0 : out_col_reg;
        orow_eff = restart ? '0 : out_row_reg;

        col_wrap = (32'(col_eff) + 32'd1) >= used_w;
        col_last = (32'(ocol_eff) + 32'd1) >= used_w;
        row_last = (32'(orow_eff) + 32'd1) >= used_h;

        s1_ctrl_next.pixel        = in_stream.pixel && !in_stream.kind;
        s1_ctrl_next.clear        = restart || clear_pend_reg;
        s1_ctrl_next.produce      = !((row_eff == '0) ||
                                      ((row_eff == RW'(1)) && (col_eff == '0)));
        s1_ctrl_next.clip_top     = (orow_eff == '0);
        s1_ctrl_next.clip_bottom  = row_last;
        s1_ctrl_next.clip_left    = (ocol_eff == '0);
        s1_ctrl_next.end_of_line  = col_last;
        s1_ctrl_next.end_of_frame = col_last && row_last;

        in_col_next     = col_wrap ? '0 : col_eff + CW'(1);
        in_row_next     = col_wrap ? row_eff + RW'(1) : row_eff;
        out_col_next    = ocol_eff;
        out_row_next    = orow_eff;
        clear_pend_next = 1'b0;

        if (s1_ctrl_next.produce)
        begin
            if (s1_ctrl_next.end_of_frame)
            begin
                in_col_next     = '0;
                in_row_next     = '0;
                out_col_next    = '0;
                out_row_next    = '0;
                clear_pend_next = 1'b1;
            end
            else if (col_last)
            begin
                out_col_next = '0;
                out_row_next = orow_eff + ORW'(1);
            end
            else
            begin
                out_col_next = ocol_eff + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg     <= '0;
            in_row_reg     <= '0;
            out_col_reg    <= '0;
            out_row_reg    <= '0;
            clear_pend_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            in_col_reg     <= '0;
            in_row_reg     <= '0;
            out_col_reg    <= '0;
            out_row_reg    <= '0;
            clear_pend_reg <= 1'b1;
        end
        else if (act)
        begin
            in_col_reg     <= in_col_next;
            in_row_reg     <= in_row_next;
            out_col_reg    <= out_col_next;
            out_row_reg    <= out_row_next;
            clear_pend_reg <= clear_pend_next;
        end
    end

    // Line RAM: read at address stage, write back at window stage
    bd3_line_store #(
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (act),
        .rd_addr (col_eff),
        .wr_en   (s1_valid_reg && s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data ({line_q[0], s1_ctrl_reg.pixel}),
        .rd_data (line_q)
    );

    // Window stage pipeline register
    assign s1_valid_next = act ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (act)
        begin
            s1_ctrl_reg <= s1_ctrl_next;
            s1_col_reg  <= col_eff;
        end
    end

    // Window shift and clipped OR
    always_comb
    begin
        win_base    = s1_ctrl_reg.clear ? '0 : window_reg;
        window_next = {s1_ctrl_reg.pixel, line_q[0], line_q[1], win_base[WIN_BITS-1:3]};
        win_mask    = '1;
        if (s1_ctrl_reg.clip_top)
            win_mask = win_mask & ~TOP_TAPS;
        if (s1_ctrl_reg.clip_bottom)
            win_mask = win_mask & ~BOTTOM_TAPS;
        if (s1_ctrl_reg.clip_left)
            win_mask = win_mask & ~LEFT_TAPS;
        if (s1_ctrl_reg.end_of_line)
            win_mask = win_mask & ~RIGHT_TAPS;
        dil_now = |(window_next & win_mask);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
        end
        else if (cfg_we)
        begin
            window_reg <= '0;
        end
        else if (s1_valid_reg && s1_adv)
        begin
            window_reg <= window_next;
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_stream.ready;
        if (s1_valid_reg && s1_adv && s1_ctrl_reg.produce)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s1_adv && s1_ctrl_reg.produce)
        begin
            dilated_reg <= dil_now;
            eol_reg     <= s1_ctrl_reg.end_of_line;
            eof_reg     <= s1_ctrl_reg.end_of_frame;
        end
    end

    assign out_stream.valid        = out_valid_reg;
    assign out_stream.dilated      = dilated_reg;
    assign out_stream.end_of_line  = eol_reg;
    assign out_stream.end_of_frame = eof_reg;

    // Checks
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> s1_valid_reg)
        else $error("window stage item dropped while stalled");

    a_eof_eol: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!eof_reg || eol_reg))
        else $error("end_of_frame without end_of_line");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(in_col_reg) < used_w) && (32'(out_col_reg) < used_w))
        else $error("column counter beyond line width");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_stream.ready && s1_valid_reg && s1_ctrl_reg.produce)
        |-> !in_stream.ready)
        else $error("input taken while result path is blocked");

endmodule

>>> verif/tb_binary_dilation_3x3_core.sv
module tb_binary_dilation_3x3_core;
    timeunit 1ns;
    timeprecision 1ps;

    import bd3_pkg::*;

    localparam int MAX_W         = 640;
    localparam int MAX_H         = 480;
    localparam logic KIND_PIXEL  = 1'b0;
    localparam logic KIND_FLUSH  = 1'b1;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_ITEMS  = 1200;
    localparam int REPORT_MAX    = 10;

    typedef struct packed {
        logic dilated;
        logic end_of_line;
        logic end_of_frame;
    } pix_result_t;

    typedef enum logic {STEP_ITEM, STEP_CFG} step_op_t;

    typedef struct {
        step_op_t    op;
        logic        kind;
        logic        pixel;
        bit          typed;
        pix_result_t want;
        logic        cfg_reg;
        int unsigned cfg_val;
    } dir_step_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    bd3_in_if  in_s();
    bd3_out_if out_s();

    binary_dilation_3x3_core #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_stream  (in_s),
        .out_stream (out_s),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // Predictor state: registers, line stores, window and raster counters
    logic [LW_BITS-1:0]  width_reg  = LW_RESET;
    logic [FH_BITS-1:0]  height_reg = FH_RESET;
    bit                  upper_mem  [MAX_W];
    bit                  middle_mem [MAX_W];
    logic [WIN_BITS-1:0] win_q   = '0;
    int unsigned         in_col  = 0;
    int unsigned         in_row  = 0;
    int unsigned         out_col = 0;
    int unsigned         out_row = 0;

    pix_result_t pending_px[$];
    int unsigned mismatch_cnt = 0;
    int unsigned cycle_cnt    = 0;
    int unsigned stim_items   = 0;
    bit          tx_eager     = 1'b0;

    // Directed sequence: 1x1 frames with typed results, then a small 3x2 frame
    dir_step_t dir_tab[$] = '{
        '{STEP_CFG,  KIND_PIXEL, 1'b0, 1'b0, 3'b000, REG_LINE_WIDTH,   1},
        '{STEP_CFG,  KIND_PIXEL, 1'b0, 1'b0, 3'b000, REG_FRAME_HEIGHT, 1},
        // flush while idle is dropped
        '{STEP_ITEM, KIND_FLUSH, 1'b1, 1'b0, 3'b000, REG_LINE_WIDTH,   0},
        '{STEP_ITEM, KIND_PIXEL, 1'b1, 1'b0, 3'b000, REG_LINE_WIDTH,   0},
        '{STEP_ITEM, KIND_FLUSH, 1'b0, 1'b0, 3'b000, REG_LINE_WIDTH,   0},
        '{STEP_ITEM, KIND_FLUSH, 1'b1, 1'b1, 3'b111, REG_LINE_WIDTH,   0},
        '{STEP_ITEM, KIND_PIXEL, 1'b0, 1'b0, 3'b000, REG_LINE_WIDTH,   0},
        '{STEP_ITEM, KIND_FLUSH, 1'b0, 1'b0, 3'b000, REG_LINE_WIDTH,   0},
        '{STEP_ITEM, KIND_FLUSH, 1'b0, 1'b1, 3'b011, REG_LINE_WIDTH,   0},
        // pixel in mid-drain abandons the lit frame and restarts with a dark one
        '{STEP_ITEM, KIND_PIXEL, 1'b1, 1'b0, 3'b000, REG_LINE_WIDTH,   0},
        '{STEP_ITEM, KIND_FLUSH, 1'b0, 1'b0, 3'b000, REG_LINE_WIDTH,   0},
        '{STEP_ITEM, KIND_PIXEL, 1'b0, 1'b0, 3'b000, REG_LINE_WIDTH,   0},
        '{STEP_ITEM, KIND_FLUSH, 1'b0, 1'b0, 3'b000, REG_LINE_WIDTH,   0},
        '{STEP_ITEM, KIND_FLUSH, 1'b0, 1'b1, 3'b011, REG_LINE_WIDTH,   0},
        // zero sizes clamp to 1x1
        '{STEP_CFG,  KIND_PIXEL, 1'b0, 1'b0, 3'b000, REG_LINE_WIDTH,   0},
        '{STEP_CFG,  KIND_PIXEL, 1'b0, 1'b0, 3'b000, REG_FRAME_HEIGHT, 0},
        '{STEP_ITEM, KIND_PIXEL, 1'b1, 1'b0, 3'b000, REG_LINE_WIDTH,   0},
        '{STEP_ITEM, KIND_FLUSH, 1'b0, 1'b0, 3'b000, REG_LINE_WIDTH,   0},
        '{STEP_ITEM, KIND_FLUSH, 1'b0, 1'b1, 3'b111, REG_LINE_WIDTH,   0},
        // single lit pixel in a 3x2 frame
        '{STEP_CFG,  KIND_PIXEL, 1'b0, 1'b0, 3'b000, REG_LINE_WIDTH,   3},
        '{STEP_CFG,  KIND_PIXEL, 1'b0, 1'b0, 3'b000, REG_FRAME_HEIGHT, 2},
        '{STEP_ITEM, KIND_PIXEL, 1'b0, 1'b0, 3'b000, REG_LINE_WIDTH,   0},
        '{STEP_ITEM, KIND_PIXEL, 1'b0, 1'b0, 3'b000, REG_LINE_WIDTH,   0},
        '{STEP_ITEM, KIND_PIXEL, 1'b0, 1'b0, 3'b000, REG_LINE_WIDTH,   0},
        '{STEP_ITEM, KIND_PIXEL, 1'b0, 1'b0, 3'b000, REG_LINE_WIDTH,   0},
        '{STEP_ITEM, KIND_PIXEL, 1'b1, 1'b0, 3'b000, REG_LINE_WIDTH,   0},
        '{STEP_ITEM, KIND_PIXEL, 1'b0, 1'b0, 3'b000, REG_LINE_WIDTH,   0},
        '{STEP_ITEM, KIND_FLUSH, 1'b1, 1'b0, 3'b000, REG_LINE_WIDTH,   0},
        '{STEP_ITEM, KIND_FLUSH, 1'b0, 1'b0, 3'b000, REG_LINE_WIDTH,   0},
        '{STEP_ITEM, KIND_FLUSH, 1'b1, 1'b0, 3'b000, REG_LINE_WIDTH,   0},
        '{STEP_ITEM, KIND_FLUSH, 1'b0, 1'b0, 3'b000, REG_LINE_WIDTH,   0}
    };

    function automatic int unsigned used_w();
        if (width_reg == 0) return 1;
        if (32'(width_reg) > MAX_W) return MAX_W;
        return 32'(width_reg);
    endfunction

    function automatic int unsigned used_h();
        if (height_reg == 0) return 1;
        if (32'(height_reg) > MAX_H) return MAX_H;
        return 32'(height_reg);
    endfunction

    function automatic void restart_frame();
        win_q   = '0;
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
    endfunction

    // Advance the predicted pipeline by one item; returns 1 when it yields a result
    function automatic bit dilate_step(input logic kind, input logic pix,
                                       output pix_result_t res);
        int unsigned w;
        int unsigned h;
        int unsigned col;
        int unsigned pos;
        logic        top;
        logic        mid;
        logic        b;
        logic [WIN_BITS-1:0] mask;
        w   = used_w();
        h   = used_h();
        b   = pix;
        res = '0;
        if (kind == KIND_FLUSH)
        begin
            // flush only counts once all pixels of the frame are in
            if (in_row < h) return 1'b0;
            b = 1'b0;
        end
        else if (in_row >= h)
        begin
            restart_frame();
        end

        col = (in_col >= MAX_W) ? 0 : in_col;
        top = upper_mem[col];
        mid = middle_mem[col];
        upper_mem[col]  = mid;
        middle_mem[col] = b;
        win_q = {b, mid, top, win_q[WIN_BITS-1:3]};

        pos = in_row * w + in_col;
        in_col++;
        if (in_col >= w)
        begin
            in_col = 0;
            in_row++;
        end
        if (pos < w + 1) return 1'b0;

        // clip the window at the frame edges
        mask = '1;
        if (out_row == 0) mask &= ~TOP_TAPS;
        if (out_row + 1 >= h) mask &= ~BOTTOM_TAPS;
        if (out_col == 0) mask &= ~LEFT_TAPS;
        if (out_col + 1 >= w) mask &= ~RIGHT_TAPS;

        res.dilated      = |(win_q & mask);
        res.end_of_line  = (out_col + 1 >= w);
        res.end_of_frame = res.end_of_line && (out_row + 1 >= h);

        if (res.end_of_frame)
        begin
            restart_frame();
        end
        else if (res.end_of_line)
        begin
            out_col = 0;
            out_row++;
        end
        else
        begin
            out_col++;
        end
        return 1'b1;
    endfunction

    task automatic flag(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_MAX) $display("mismatch @%0t: %s", $time, msg);
    endtask

    // Mostly short gaps, occasionally a long one
    function automatic int unsigned pick_gap();
        if ($urandom_range(9) == 0) return $urandom_range(40, 10);
        return $urandom_range(3, 1);
    endfunction

    // One APB transfer: setup cycle, then access cycle until pready
    task automatic apb_xfer(input logic wr, input logic reg_sel,
                            input logic [PDATA_W-1:0] wdata,
                            output logic [PDATA_W-1:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write a register, mirror it in the predictor and read it back
    task automatic set_register(input logic reg_sel, input int unsigned value);
        logic [PDATA_W-1:0] rd;
        logic [PDATA_W-1:0] want;
        apb_xfer(1'b1, reg_sel, value, rd);
        if (reg_sel == REG_LINE_WIDTH)
        begin
            width_reg = value[LW_BITS-1:0];
            want      = PDATA_W'(width_reg);
        end
        else
        begin
            height_reg = value[FH_BITS-1:0];
            want       = PDATA_W'(height_reg);
        end
        restart_frame();
        apb_xfer(1'b0, reg_sel, '0, rd);
        if (rd !== want)
            flag($sformatf("register %0d readback exp %0d got %0d", reg_sel, want, rd));
    endtask

    // Drop valid and hold off until every expected result has come out
    task automatic quiesce();
        @(negedge clk);
        in_s.valid <= 1'b0;
        while (pending_px.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Present one item, wait for the transfer, then log its expected result
    task automatic send_item(input logic kind, input logic pixel, input bit typed,
                             input pix_result_t want);
        int unsigned gap;
        pix_result_t res;
        bit          got;
        gap = (!tx_eager && $urandom_range(99) < 30) ? pick_gap() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_s.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_s.valid <= 1'b1;
        in_s.kind  <= kind;
        in_s.pixel <= pixel;
        do @(posedge clk); while (in_s.ready !== 1'b1);
        got = dilate_step(kind, pixel, res);
        if (got || typed) pending_px.push_back(typed ? want : res);
    endtask

    // Pixels of one frame at a random density, stray flushes mixed in,
    // then the drain ticks and any extra ticks past the end of frame
    task automatic run_frame(input int unsigned npix, input int unsigned drain,
                             input int unsigned extra);
        int unsigned thr;
        case ($urandom_range(2))
            0:       thr = 3;
            1:       thr = 50;
            default: thr = 92;
        endcase
        for (int unsigned i = 0; i < npix; i++)
        begin
            if ($urandom_range(99) < 3)
                send_item(KIND_FLUSH, 1'($urandom_range(1)), 1'b0, '0);
            if ($urandom_range(299) == 0) quiesce();
            send_item(KIND_PIXEL, 1'($urandom_range(99) < thr), 1'b0, '0);
        end
        repeat (drain + extra) send_item(KIND_FLUSH, 1'($urandom_range(1)), 1'b0, '0);
        stim_items += npix + drain;
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Cycle limit
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Output side back-pressure: eager stretches alternate with random stalls
    initial
    begin : rx_stall_gen
        int unsigned hold;
        int unsigned span;
        bit          eager;
        hold  = 0;
        span  = 0;
        eager = 1'b0;
        out_s.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (span == 0)
            begin
                eager = ($urandom_range(3) == 0);
                span  = $urandom_range(300, 50);
            end
            span--;
            if (hold > 0)
            begin
                hold--;
                out_s.ready <= 1'b0;
            end
            else if (!eager && $urandom_range(99) < 25)
            begin
                hold = pick_gap() - 1;
                out_s.ready <= 1'b0;
            end
            else
            begin
                out_s.ready <= 1'b1;
            end
        end
    end

    // Compare each output transfer with the oldest expected result
    always @(posedge clk)
    begin
        pix_result_t want;
        pix_result_t seen;
        if (rst_n && out_s.valid === 1'b1 && out_s.ready === 1'b1)
        begin
            seen = {out_s.dilated, out_s.end_of_line, out_s.end_of_frame};
            if (pending_px.size() == 0)
            begin
                flag($sformatf("unexpected result dil=%b eol=%b eof=%b",
                               seen.dilated, seen.end_of_line, seen.end_of_frame));
            end
            else
            begin
                want = pending_px.pop_front();
                if (seen !== want)
                    flag($sformatf("dil/eol/eof exp %b/%b/%b got %b/%b/%b",
                                   want.dilated, want.end_of_line, want.end_of_frame,
                                   seen.dilated, seen.end_of_line, seen.end_of_frame));
            end
        end
    end

    // Stimulus
    initial
    begin
        logic [PDATA_W-1:0] rd;
        int unsigned raw_w;
        int unsigned raw_h;
        int unsigned w;
        int unsigned h;
        int unsigned npix;
        int unsigned drain;
        int unsigned extra;
        bit          first_phase;

        rst_n       = 1'b0;
        in_s.valid  = 1'b0;
        in_s.kind   = KIND_PIXEL;
        in_s.pixel  = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        first_phase = 1'b1;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // register values after reset
        apb_xfer(1'b0, REG_LINE_WIDTH, '0, rd);
        if (rd !== PDATA_W'(LW_RESET)) flag($sformatf("line_width after reset: %0d", rd));
        apb_xfer(1'b0, REG_FRAME_HEIGHT, '0, rd);
        if (rd !== PDATA_W'(FH_RESET)) flag($sformatf("frame_height after reset: %0d", rd));

        // widest frame (oversized width clamps), also fills both line stores
        set_register(REG_LINE_WIDTH, 1023);
        set_register(REG_FRAME_HEIGHT, 2);
        run_frame(MAX_W * 2, MAX_W + 1, 0);
        quiesce();

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].op == STEP_CFG)
            begin
                quiesce();
                set_register(dir_tab[i].cfg_reg, dir_tab[i].cfg_val);
            end
            else
            begin
                send_item(dir_tab[i].kind, dir_tab[i].pixel, dir_tab[i].typed,
                          dir_tab[i].want);
            end
        end

        // Random phases: new sizes, then a few frames at those sizes
        stim_items = 0;
        while (stim_items < RANDOM_ITEMS)
        begin
            quiesce();
            case ($urandom_range(19))
                0:       raw_w = 0;
                1, 2:    raw_w = $urandom_range(40, 9);
                default: raw_w = $urandom_range(8, 1);
            endcase
            case ($urandom_range(19))
                0:       raw_h = 0;
                1:       raw_h = $urandom_range(12, 7);
                default: raw_h = $urandom_range(6, 1);
            endcase
            if (first_phase)
            begin
                // tallest frame, oversized height clamps
                raw_w = 1;
                raw_h = 511;
            end
            if (first_phase || $urandom_range(3) != 0)
            begin
                set_register(REG_LINE_WIDTH, raw_w);
                set_register(REG_FRAME_HEIGHT, raw_h);
            end
            else if ($urandom_range(1) == 0)
            begin
                set_register(REG_LINE_WIDTH, raw_w);
            end
            else
            begin
                set_register(REG_FRAME_HEIGHT, raw_h);
            end
            first_phase = 1'b0;
            w = used_w();
            h = used_h();
            tx_eager = ($urandom_range(3) == 0);
            repeat ($urandom_range(3, 1))
            begin
                npix  = ($urandom_range(19) == 0) ? $urandom_range(w * h, 1) : w * h;
                drain = w + 1;
                extra = 0;
                case ($urandom_range(9))
                    0: drain = $urandom_range(w, 0);
                    1: extra = $urandom_range(3, 1);
                    default: ;
                endcase
                run_frame(npix, drain, extra);
            end
        end

        // Let the pipeline empty, then report
        @(negedge clk);
        in_s.valid <= 1'b0;
        for (int i = 0; i < DRAIN_LIMIT && pending_px.size() != 0; i++) @(posedge clk);
        repeat (SETTLE_CYCLES * 2) @(posedge clk);
        if (pending_px.size() != 0)
            flag($sformatf("%0d expected results never came out", pending_px.size()));
        if (mismatch_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> filelist.f
sv/bd3_pkg.sv
sv/bd3_if.sv
sv/bd3_line_store.sv
sv/binary_dilation_3x3_core.sv
verif/tb_binary_dilation_3x3_core.sv
